// File: src/wso_pkg.sv
// Shared types, widths and constants for the wheel speed odometer unit.
// No dependencies; every other source file refers to this package by scoped names.
package wso_pkg;

   localparam int TURNS_PER_MEASURE = 5;
   localparam int AVG_WINDOW        = 4;

   localparam int TIME_W     = 32;
   localparam int WHEEL_W    = 12;
   localparam int RPM_W      = 10;
   localparam int TIMEOUT_W  = 16;
   localparam int STEP_W     = 24;
   localparam int DIST_W     = 40;
   localparam int SPEED_W    = 22;
   localparam int PERIOD_W   = 25;
   localparam int DIV_W      = 16;
   localparam int TURN_CNT_W = $clog2(TURNS_PER_MEASURE + 1);
   localparam int HIST_IDX_W = $clog2(AVG_WINDOW);
   localparam int SUM_W      = SPEED_W + $clog2(AVG_WINDOW);

   localparam int CSR_ADDR_W    = 6;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_INDEX_LSB = 3;
   localparam int CSR_INDEX_W   = CSR_ADDR_W - CSR_INDEX_LSB;

   localparam logic [DIV_W-1:0]   RPM_NUMERATOR = 16'd60000;
   localparam logic [DIV_W-1:0]   AVG_MAX       = {DIV_W{1'b1}};
   localparam logic [DIST_W-1:0]  DIST_MAX      = {DIST_W{1'b1}};

   localparam logic [WHEEL_W-1:0]   WHEEL_LENGTH_RESET = 12'd2100;
   localparam logic [RPM_W-1:0]     RPM_LIMIT_RESET    = 10'd600;
   localparam logic [TIMEOUT_W-1:0] IDLE_TIMEOUT_RESET = 16'd4000;
   localparam logic [STEP_W-1:0]    SAVE_STEP_RESET    = 24'd1000000;
   localparam logic [DIST_W-1:0]    TOTAL_START_RESET  = 40'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WHEEL_LENGTH = 3'd0,
      CSR_RPM_LIMIT    = 3'd1,
      CSR_IDLE_TIMEOUT = 3'd2,
      CSR_SAVE_STEP    = 3'd3,
      CSR_TOTAL_START  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic              sensor_level;
   } req_payload_type;

   typedef struct packed {
      logic [RPM_W-1:0]   turn_rate;
      logic [SPEED_W-1:0] speed_now;
      logic [SPEED_W-1:0] speed_peak;
      logic [SPEED_W-1:0] speed_mean;
      logic [DIST_W-1:0]  trip_mm;
      logic [DIST_W-1:0]  odometer_mm;
      logic               save_pulse;
      logic               went_idle;
   } rsp_payload_type;

   typedef struct packed {
      logic [WHEEL_W-1:0]   wheel_length_mm;
      logic [RPM_W-1:0]     rpm_limit;
      logic [TIMEOUT_W-1:0] idle_timeout_ms;
      logic [STEP_W-1:0]    save_step_mm;
      logic [DIST_W-1:0]    total_start_mm;
      logic                 total_load;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_WAIT,
      ST_TURN,
      ST_SAVE,
      ST_MEASURE,
      ST_DIVIDE,
      ST_SCALE,
      ST_PEAK,
      ST_SUM,
      ST_BLEND,
      ST_CHECK,
      ST_DONE
   } state_type;

endpackage

// File: src/wso_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle, for the rpm measurement.
// Depends on wso_pkg for the operand width.
module wso_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [wso_pkg::DIV_W-1:0] dividend,
   input  logic [wso_pkg::DIV_W-1:0] divisor,
   output logic                      done,
   output logic [wso_pkg::DIV_W-1:0] quotient
);

   localparam int CNT_W = $clog2(wso_pkg::DIV_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(wso_pkg::DIV_W - 1);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [wso_pkg::DIV_W-1:0] rem_ff, rem_in;
   logic [wso_pkg::DIV_W-1:0] quo_ff, quo_in;
   logic [wso_pkg::DIV_W-1:0] divisor_ff, divisor_in;
   logic [wso_pkg::DIV_W:0]   trial;
   logic [wso_pkg::DIV_W:0]   diff;

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      trial      = {rem_ff, quo_ff[wso_pkg::DIV_W-1]};
      diff       = trial - {1'b0, divisor_ff};
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         // keep the partial remainder when the trial subtract borrows
         if (!diff[wso_pkg::DIV_W]) begin
            rem_in = diff[wso_pkg::DIV_W-1:0];
            quo_in = {quo_ff[wso_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[wso_pkg::DIV_W-1:0];
            quo_in = {quo_ff[wso_pkg::DIV_W-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: src/wso_csr.sv
// APB-style configuration registers of the wheel speed odometer unit.
// Depends on wso_pkg for register codes, reset values and the cfg_type struct.
module wso_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [wso_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [wso_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [wso_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output wso_pkg::cfg_type               cfg
);

   logic [wso_pkg::WHEEL_W-1:0]   wheel_ff, wheel_in;
   logic [wso_pkg::RPM_W-1:0]     limit_ff, limit_in;
   logic [wso_pkg::TIMEOUT_W-1:0] timeout_ff, timeout_in;
   logic [wso_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [wso_pkg::DIST_W-1:0]    start_ff, start_in;
   logic                          write_en;
   logic                          total_load;
   wso_pkg::csr_index_type        index;

   assign index    = wso_pkg::csr_index_type'(paddr[wso_pkg::CSR_ADDR_W-1:wso_pkg::CSR_INDEX_LSB]);
   assign write_en = psel && penable && pwrite;

   always_comb begin
      wheel_in   = wheel_ff;
      limit_in   = limit_ff;
      timeout_in = timeout_ff;
      step_in    = step_ff;
      start_in   = start_ff;
      total_load = 1'b0;
      prdata     = '0;
      case (index)
         wso_pkg::CSR_WHEEL_LENGTH: begin
            prdata = wso_pkg::CSR_DATA_W'(wheel_ff);
            if (write_en) wheel_in = pwdata[wso_pkg::WHEEL_W-1:0];
         end
         wso_pkg::CSR_RPM_LIMIT: begin
            prdata = wso_pkg::CSR_DATA_W'(limit_ff);
            if (write_en) limit_in = pwdata[wso_pkg::RPM_W-1:0];
         end
         wso_pkg::CSR_IDLE_TIMEOUT: begin
            prdata = wso_pkg::CSR_DATA_W'(timeout_ff);
            if (write_en) timeout_in = pwdata[wso_pkg::TIMEOUT_W-1:0];
         end
         wso_pkg::CSR_SAVE_STEP: begin
            prdata = wso_pkg::CSR_DATA_W'(step_ff);
            if (write_en) step_in = pwdata[wso_pkg::STEP_W-1:0];
         end
         wso_pkg::CSR_TOTAL_START: begin
            prdata = wso_pkg::CSR_DATA_W'(start_ff);
            if (write_en) begin
               start_in   = pwdata[wso_pkg::DIST_W-1:0];
               total_load = 1'b1;
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wheel_ff   <= wso_pkg::WHEEL_LENGTH_RESET;
         limit_ff   <= wso_pkg::RPM_LIMIT_RESET;
         timeout_ff <= wso_pkg::IDLE_TIMEOUT_RESET;
         step_ff    <= wso_pkg::SAVE_STEP_RESET;
         start_ff   <= wso_pkg::TOTAL_START_RESET;
      end else begin
         wheel_ff   <= wheel_in;
         limit_ff   <= limit_in;
         timeout_ff <= timeout_in;
         step_ff    <= step_in;
         start_ff   <= start_in;
      end
   end

   assign pready = 1'b1;

   always_comb begin
      cfg.wheel_length_mm = wheel_ff;
      cfg.rpm_limit       = limit_ff;
      cfg.idle_timeout_ms = timeout_ff;
      cfg.save_step_mm    = step_ff;
      cfg.total_start_mm  = pwdata[wso_pkg::DIST_W-1:0];
      cfg.total_load      = total_load;
   end

endmodule

// File: src/wheel_speed_odometer_unit.sv
// Top level of the wheel speed odometer unit: sequencer, state and result register.
// Depends on wso_pkg, wso_divider and wso_csr.
//
// Usage:
//   req channel: one beat per hall sensor sample (millisecond timestamp and level).
//   rsp channel: exactly one beat per sample with rpm, speed (mm/min), peak and
//   mean speed, trip and total distance, a save pulse and an idle flag.
//   Configuration: APB-style writes at 8*index, only while no sample is in work.
//   Writing the total start register also loads the running total.
// Sequence:
//   A sample without a turn passes the turn, check and done steps; a turn
//   without a measurement also passes the save step. Every fifth turn runs the
//   16-step restoring divider (60000 / average turn time) plus scaling, peak and
//   averaging steps. The sequencer holds one sample at a time and stalls the req
//   channel until that sample's result is out, so no new sample enters meanwhile.
//   A finished result sits in the output register while the next sample is
//   accepted; if the receiver stalls, the sequencer holds in its last step
//   until the pending beat is taken.
// Reset: synchronous, active high. Clears all counters, speed, distance and
//   flags, restores register defaults; the speed history needs no clearing.
module wheel_speed_odometer_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  wso_pkg::req_payload_type       req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output wso_pkg::rsp_payload_type       rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [wso_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [wso_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [wso_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   localparam logic [wso_pkg::TURN_CNT_W-1:0] TURN_LAST =
      wso_pkg::TURN_CNT_W'(wso_pkg::TURNS_PER_MEASURE);
   localparam logic [wso_pkg::HIST_IDX_W-1:0] HIST_LAST =
      wso_pkg::HIST_IDX_W'(wso_pkg::AVG_WINDOW - 1);
   localparam logic [wso_pkg::TIME_W-1:0] TURN_GAPS =
      wso_pkg::TIME_W'(wso_pkg::TURNS_PER_MEASURE - 1);
   localparam logic [wso_pkg::SUM_W-1:0] AVG_DEPTH =
      wso_pkg::SUM_W'(wso_pkg::AVG_WINDOW);

   wso_pkg::cfg_type cfg;

   wso_pkg::state_type state_ff, state_in;

   logic [wso_pkg::TIME_W-1:0]     now_ff, now_in;
   logic                           level_ff, level_in;
   logic                           armed_ff, armed_in;
   logic [wso_pkg::TIME_W-1:0]     last_turn_ff, last_turn_in;
   logic [wso_pkg::TIME_W-1:0]     wstart_ff, wstart_in;
   logic                           wvalid_ff, wvalid_in;
   logic [wso_pkg::TURN_CNT_W-1:0] count_ff, count_in;
   logic                           measure_ff, measure_in;
   logic [wso_pkg::RPM_W-1:0]      rpm_ff, rpm_in;
   logic [wso_pkg::SPEED_W-1:0]    speed_ff, speed_in;
   logic [wso_pkg::SPEED_W-1:0]    peak_ff, peak_in;
   logic [wso_pkg::SPEED_W-1:0]    mean_ff, mean_in;
   logic [wso_pkg::SPEED_W-1:0]    hist_ff [wso_pkg::AVG_WINDOW];
   logic                           hist_we;
   logic [wso_pkg::HIST_IDX_W-1:0] idx_ff, idx_in;
   logic [wso_pkg::SUM_W-1:0]      sum_ff, sum_in;
   logic [wso_pkg::DIST_W-1:0]     trip_ff, trip_in;
   logic [wso_pkg::PERIOD_W-1:0]   period_ff, period_in;
   logic [wso_pkg::DIST_W-1:0]     total_ff, total_in;
   logic                           save_ff, save_in;
   logic                           idled_ff, idled_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   wso_pkg::rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic                           div_start;
   logic [wso_pkg::DIV_W-1:0]      div_divisor;
   logic                           div_done;
   logic [wso_pkg::DIV_W-1:0]      div_quotient;

   logic [wso_pkg::TURN_CNT_W-1:0] count_next;
   logic [wso_pkg::DIST_W:0]       trip_sum;
   logic [wso_pkg::DIST_W:0]       total_sum;
   logic [wso_pkg::TIME_W-1:0]     interval;
   logic [wso_pkg::TIME_W-1:0]     gap;
   logic [wso_pkg::DIV_W-1:0]      avg_gap;
   logic [wso_pkg::SUM_W-1:0]      window_avg;
   logic [wso_pkg::SPEED_W:0]      blend_sum;
   logic [wso_pkg::TIME_W-1:0]     since_turn;

   wso_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   wso_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (wso_pkg::RPM_NUMERATOR),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Datapath values that feed the sequencer steps.
   always_comb begin
      count_next = count_ff + 1'b1;
      trip_sum   = {1'b0, trip_ff} + (wso_pkg::DIST_W + 1)'(cfg.wheel_length_mm);
      total_sum  = {1'b0, total_ff} + (wso_pkg::DIST_W + 1)'(period_ff);
      interval   = now_ff - wstart_ff;
      gap        = interval / TURN_GAPS;
      avg_gap    = (gap > wso_pkg::TIME_W'(wso_pkg::AVG_MAX)) ?
                   wso_pkg::AVG_MAX : gap[wso_pkg::DIV_W-1:0];
      window_avg = sum_ff / AVG_DEPTH;
      blend_sum  = {1'b0, mean_ff} + window_avg[wso_pkg::SPEED_W:0];
      since_turn = now_ff - last_turn_ff;
   end

   always_comb begin
      state_in     = state_ff;
      now_in       = now_ff;
      level_in     = level_ff;
      armed_in     = armed_ff;
      last_turn_in = last_turn_ff;
      wstart_in    = wstart_ff;
      wvalid_in    = wvalid_ff;
      count_in     = count_ff;
      measure_in   = measure_ff;
      rpm_in       = rpm_ff;
      speed_in     = speed_ff;
      peak_in      = peak_ff;
      mean_in      = mean_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      trip_in      = trip_ff;
      period_in    = period_ff;
      total_in     = total_ff;
      save_in      = save_ff;
      idled_in     = idled_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      hist_we      = 1'b0;
      div_start    = 1'b0;
      div_divisor  = avg_gap;
      req_stall    = (state_ff != wso_pkg::ST_WAIT);

      case (state_ff)
         wso_pkg::ST_WAIT: begin
            if (req_valid) begin
               now_in     = req_data.now_ms;
               level_in   = req_data.sensor_level;
               save_in    = 1'b0;
               idled_in   = 1'b0;
               measure_in = 1'b0;
               state_in   = wso_pkg::ST_TURN;
            end
         end
         wso_pkg::ST_TURN: begin
            if (!level_ff) begin
               armed_in = 1'b1;
               state_in = wso_pkg::ST_CHECK;
            end else if (armed_ff) begin
               armed_in     = 1'b0;
               last_turn_in = now_ff;
               if (!wvalid_ff) begin
                  wstart_in = now_ff;
                  wvalid_in = 1'b1;
               end
               if (count_next >= TURN_LAST) begin
                  measure_in = 1'b1;
                  count_in   = '0;
                  wvalid_in  = 1'b0;
               end else begin
                  count_in = count_next;
               end
               trip_in   = trip_sum[wso_pkg::DIST_W] ? wso_pkg::DIST_MAX :
                           trip_sum[wso_pkg::DIST_W-1:0];
               period_in = period_ff + wso_pkg::PERIOD_W'(cfg.wheel_length_mm);
               state_in  = wso_pkg::ST_SAVE;
            end else begin
               state_in = wso_pkg::ST_CHECK;
            end
         end
         wso_pkg::ST_SAVE: begin
            // fold the period distance into the total once it reaches the step
            if (period_ff >= wso_pkg::PERIOD_W'(cfg.save_step_mm)) begin
               total_in  = total_sum[wso_pkg::DIST_W] ? wso_pkg::DIST_MAX :
                           total_sum[wso_pkg::DIST_W-1:0];
               period_in = '0;
               save_in   = 1'b1;
            end
            state_in = measure_ff ? wso_pkg::ST_MEASURE : wso_pkg::ST_CHECK;
         end
         wso_pkg::ST_MEASURE: begin
            // a zero average interval is dropped rather than divided by
            if (avg_gap == '0) begin
               state_in = wso_pkg::ST_CHECK;
            end else begin
               div_start = 1'b1;
               state_in  = wso_pkg::ST_DIVIDE;
            end
         end
         wso_pkg::ST_DIVIDE: begin
            if (div_done) state_in = wso_pkg::ST_SCALE;
         end
         wso_pkg::ST_SCALE: begin
            if (div_quotient < wso_pkg::DIV_W'(cfg.rpm_limit)) begin
               rpm_in   = div_quotient[wso_pkg::RPM_W-1:0];
               speed_in = wso_pkg::SPEED_W'(div_quotient[wso_pkg::RPM_W-1:0]) *
                          wso_pkg::SPEED_W'(cfg.wheel_length_mm);
               state_in = wso_pkg::ST_PEAK;
            end else begin
               state_in = wso_pkg::ST_CHECK;
            end
         end
         wso_pkg::ST_PEAK: begin
            if (speed_ff >= peak_ff) peak_in = speed_ff;
            state_in = wso_pkg::ST_CHECK;
            if (speed_ff != '0) begin
               hist_we = 1'b1;
               if (idx_ff == HIST_LAST) begin
                  idx_in   = '0;
                  state_in = wso_pkg::ST_SUM;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         wso_pkg::ST_SUM: begin
            sum_in = '0;
            for (int i = 0; i < wso_pkg::AVG_WINDOW; i++) begin
               sum_in = sum_in + wso_pkg::SUM_W'(hist_ff[i]);
            end
            state_in = wso_pkg::ST_BLEND;
         end
         wso_pkg::ST_BLEND: begin
            if (mean_ff == '0) begin
               mean_in = window_avg[wso_pkg::SPEED_W-1:0];
            end else begin
               mean_in = blend_sum[wso_pkg::SPEED_W:1];
            end
            state_in = wso_pkg::ST_CHECK;
         end
         wso_pkg::ST_CHECK: begin
            if (speed_ff != '0 &&
                since_turn >= wso_pkg::TIME_W'(cfg.idle_timeout_ms)) begin
               speed_in  = '0;
               rpm_in    = '0;
               count_in  = '0;
               wvalid_in = 1'b0;
               idled_in  = 1'b1;
            end
            state_in = wso_pkg::ST_DONE;
         end
         wso_pkg::ST_DONE: begin
            // hold here until the previous beat has left the output register
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.turn_rate   = rpm_ff;
               rsp_data_in.speed_now   = speed_ff;
               rsp_data_in.speed_peak  = peak_ff;
               rsp_data_in.speed_mean  = mean_ff;
               rsp_data_in.trip_mm     = trip_ff;
               rsp_data_in.odometer_mm = total_ff;
               rsp_data_in.save_pulse  = save_ff;
               rsp_data_in.went_idle   = idled_ff;
               rsp_valid_in            = 1'b1;
               state_in                = wso_pkg::ST_WAIT;
            end
         end
         default: begin
            state_in = wso_pkg::ST_WAIT;
         end
      endcase

      if (cfg.total_load) total_in = cfg.total_start_mm;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wso_pkg::ST_WAIT;
         armed_ff     <= 1'b0;
         last_turn_ff <= '0;
         wstart_ff    <= '0;
         wvalid_ff    <= 1'b0;
         count_ff     <= '0;
         measure_ff   <= 1'b0;
         rpm_ff       <= '0;
         speed_ff     <= '0;
         peak_ff      <= '0;
         mean_ff      <= '0;
         idx_ff       <= '0;
         trip_ff      <= '0;
         period_ff    <= '0;
         total_ff     <= wso_pkg::TOTAL_START_RESET;
         save_ff      <= 1'b0;
         idled_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         armed_ff     <= armed_in;
         last_turn_ff <= last_turn_in;
         wstart_ff    <= wstart_in;
         wvalid_ff    <= wvalid_in;
         count_ff     <= count_in;
         measure_ff   <= measure_in;
         rpm_ff       <= rpm_in;
         speed_ff     <= speed_in;
         peak_ff      <= peak_in;
         mean_ff      <= mean_in;
         idx_ff       <= idx_in;
         trip_ff      <= trip_in;
         period_ff    <= period_in;
         total_ff     <= total_in;
         save_ff      <= save_in;
         idled_ff     <= idled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff      <= now_in;
      level_ff    <= level_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   // speed history: written only by the peak step, read by the sum step
   always_ff @(posedge clock) begin
      if (hist_we) hist_ff[idx_ff] <= speed_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_starts_turn: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == wso_pkg::ST_TURN))
      else $error("accepted sample did not start the turn step");

   a_speed_has_rpm: assert property (@(posedge clock) disable iff (reset)
      (speed_ff != '0) |-> (rpm_ff != '0))
      else $error("nonzero speed without a nonzero rpm");

   a_peak_covers_speed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wso_pkg::ST_WAIT) |-> (peak_ff >= speed_ff))
      else $error("peak speed below current speed between samples");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == wso_pkg::ST_DONE))
      else $error("result beat raised outside the done step");

endmodule

// File: verif/tb_top.sv
// Self-checking bench for wheel_speed_odometer_unit: directed and random sensor samples.
// Holds its own cycle-free predictor and drives the APB-style settings port.
// Depends on wso_pkg and the wheel_speed_odometer_unit RTL.
module tb_top;

   localparam int IDLE_PCT    = 28;    // chance in a hundred that a side idles a cycle
   localparam int STALL_LIMIT = 3000;  // cycles with no beat before the run is given up
   localparam int DRAIN_WAIT  = 40;    // settling wait after the last readout
   localparam int LONG_HOLD   = 400;   // receiver hold-off in the back-pressure test

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   wso_pkg::req_payload_type       req_data;
   logic                           rsp_valid;
   logic                           rsp_stall;
   wso_pkg::rsp_payload_type       rsp_data;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [wso_pkg::CSR_ADDR_W-1:0] paddr;
   logic [wso_pkg::CSR_DATA_W-1:0] pwdata;
   logic [wso_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   wheel_speed_odometer_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Predictor state: a private copy of the settings and of everything the
   // meter remembers between samples.
   // ---------------------------------------------------------------------------
   logic [wso_pkg::WHEEL_W-1:0]   wheel_mm;
   logic [wso_pkg::RPM_W-1:0]     rpm_ceiling;
   logic [wso_pkg::TIMEOUT_W-1:0] idle_limit_ms;
   logic [wso_pkg::STEP_W-1:0]    save_step;

   logic                          armed_now;
   logic [wso_pkg::TIME_W-1:0]    last_turn_ms;
   logic [wso_pkg::TIME_W-1:0]    window_start_ms;
   logic                          window_open;
   int unsigned                   turns_in_window;
   logic [wso_pkg::RPM_W-1:0]     rpm_held;
   logic [22:0]                   speed_held;
   logic [22:0]                   peak_held;
   logic [22:0]                   mean_held;
   logic [22:0]                   speed_log [wso_pkg::AVG_WINDOW];
   int unsigned                   log_fill;
   logic [wso_pkg::DIST_W-1:0]    trip_held;
   logic [wso_pkg::PERIOD_W-1:0]  period_held;
   logic [wso_pkg::DIST_W-1:0]    total_held;

   wso_pkg::rsp_payload_type      readouts_due [$];   // predicted readouts, oldest first
   int unsigned                   samples_sent;
   int unsigned                   errors;             // result side mismatches
   int unsigned                   csr_errors;         // register readback mismatches
   logic [wso_pkg::TIME_W-1:0]    ride_ms;            // timeline cursor for generated rides
   logic                          steady;             // when set neither side idles
   int unsigned                   holds_asked;        // long receiver hold-offs requested

   function automatic logic [wso_pkg::DIST_W-1:0] clamp_add(
      input logic [wso_pkg::DIST_W-1:0] a,
      input logic [wso_pkg::DIST_W-1:0] b);
      logic [wso_pkg::DIST_W:0] wide;
      wide = {1'b0, a} + {1'b0, b};
      return wide[wso_pkg::DIST_W] ? wso_pkg::DIST_MAX : wide[wso_pkg::DIST_W-1:0];
   endfunction

   // Advance the predictor by one sample and build the readout it must produce.
   task automatic advance_meter(input wso_pkg::req_payload_type beat,
                                output wso_pkg::rsp_payload_type want);
      logic              saved;
      logic              idled;
      logic [31:0]       interval;
      logic [31:0]       avg;
      logic [31:0]       rpm;
      logic [31:0]       since_turn;
      logic [26:0]       sum;
      saved = 1'b0;
      idled = 1'b0;
      if (!beat.sensor_level) begin
         armed_now = 1'b1;
      end else if (armed_now) begin
         armed_now    = 1'b0;
         last_turn_ms = beat.now_ms;
         if (!window_open) begin
            window_start_ms = beat.now_ms;
            window_open     = 1'b1;
         end
         turns_in_window++;
         if (turns_in_window >= wso_pkg::TURNS_PER_MEASURE) begin
            interval = last_turn_ms - window_start_ms;
            avg      = interval / 32'(wso_pkg::TURNS_PER_MEASURE - 1);
            if (avg > 32'd65535) avg = 32'd65535;
            // a zero average is dropped rather than divided by
            if (avg != 0) begin
               rpm = 32'd60000 / avg;
               if (rpm < 32'(rpm_ceiling)) begin
                  rpm_held   = rpm[wso_pkg::RPM_W-1:0];
                  speed_held = 23'(rpm * 32'(wheel_mm));
                  if (speed_held >= peak_held) peak_held = speed_held;
                  if (speed_held != 0) begin
                     speed_log[log_fill] = speed_held;
                     log_fill++;
                     if (log_fill >= wso_pkg::AVG_WINDOW) begin
                        sum = '0;
                        for (int i = 0; i < wso_pkg::AVG_WINDOW; i++)
                           sum += 27'(speed_log[i]);
                        sum = sum / 27'(wso_pkg::AVG_WINDOW);
                        mean_held = (mean_held == '0) ? sum[22:0] :
                                    23'((27'(mean_held) + sum) >> 1);
                        log_fill  = 0;
                     end
                  end
               end
            end
            turns_in_window = 0;
            window_open     = 1'b0;
         end
         trip_held   = clamp_add(trip_held, wso_pkg::DIST_W'(wheel_mm));
         period_held = period_held + wso_pkg::PERIOD_W'(wheel_mm);
         if (period_held >= wso_pkg::PERIOD_W'(save_step)) begin
            total_held  = clamp_add(total_held, wso_pkg::DIST_W'(period_held));
            period_held = '0;
            saved       = 1'b1;
         end
      end
      since_turn = beat.now_ms - last_turn_ms;
      if (speed_held != 0 && since_turn >= 32'(idle_limit_ms)) begin
         speed_held      = '0;
         rpm_held        = '0;
         turns_in_window = 0;
         window_open     = 1'b0;
         idled           = 1'b1;
      end
      want.turn_rate   = rpm_held;
      want.speed_now   = speed_held[wso_pkg::SPEED_W-1:0];
      want.speed_peak  = peak_held[wso_pkg::SPEED_W-1:0];
      want.speed_mean  = mean_held[wso_pkg::SPEED_W-1:0];
      want.trip_mm     = trip_held;
      want.odometer_mm = total_held;
      want.save_pulse  = saved;
      want.went_idle   = idled;
   endtask

   // Report one field; returns 1 when it matches.
   function automatic bit field_ok(input string name, input logic [63:0] want,
                                   input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------------
   // Result side: take each rsp beat at the rising edge and compare it field
   // by field with the oldest prediction.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      wso_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (readouts_due.size() == 0) begin
            $display("%0t: unexpected rsp beat, expected none, actual %p", $time, rsp_data);
            errors++;
         end else begin
            want = readouts_due.pop_front();
            if (!field_ok("turn_rate", 64'(want.turn_rate), 64'(rsp_data.turn_rate)))
               errors++;
            if (!field_ok("speed_now", 64'(want.speed_now), 64'(rsp_data.speed_now)))
               errors++;
            if (!field_ok("speed_peak", 64'(want.speed_peak), 64'(rsp_data.speed_peak)))
               errors++;
            if (!field_ok("speed_mean", 64'(want.speed_mean), 64'(rsp_data.speed_mean)))
               errors++;
            if (!field_ok("trip_mm", 64'(want.trip_mm), 64'(rsp_data.trip_mm)))
               errors++;
            if (!field_ok("odometer_mm", 64'(want.odometer_mm),
                          64'(rsp_data.odometer_mm)))
               errors++;
            if (!field_ok("save_pulse", 64'(want.save_pulse), 64'(rsp_data.save_pulse)))
               errors++;
            if (!field_ok("went_idle", 64'(want.went_idle), 64'(rsp_data.went_idle)))
               errors++;
         end
      end
   end

   // Receiver: stall at random, or hold off for a long counted stretch when asked.
   always @(negedge clock) begin
      int unsigned hold_left;
      int unsigned holds_done;
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (holds_done != holds_asked) begin
         holds_done++;
         hold_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // Watchdog: give up once no beat of any kind has moved for too long.
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("FAIL wheel_speed_odometer_unit");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------------

   // Offer one sample beat, idling first at random; predict it once accepted.
   task automatic send_sample(input logic [wso_pkg::TIME_W-1:0] now, input logic level);
      wso_pkg::req_payload_type beat;
      wso_pkg::rsp_payload_type want;
      beat.now_ms       = now;
      beat.sensor_level = level;
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall !== 1'b0);
      advance_meter(beat, want);
      readouts_due.push_back(want);
      samples_sent++;
   endtask

   // Drop valid, wait for every predicted readout, then let the block go quiet.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (readouts_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // Write one setting (setup, access), then read it back the same way.
   task automatic csr_write(input wso_pkg::csr_index_type idx, input logic [63:0] value);
      logic [63:0] stored;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, {wso_pkg::CSR_INDEX_LSB{1'b0}}};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (idx)
         wso_pkg::CSR_WHEEL_LENGTH: wheel_mm      = value[wso_pkg::WHEEL_W-1:0];
         wso_pkg::CSR_RPM_LIMIT:    rpm_ceiling   = value[wso_pkg::RPM_W-1:0];
         wso_pkg::CSR_IDLE_TIMEOUT: idle_limit_ms = value[wso_pkg::TIMEOUT_W-1:0];
         wso_pkg::CSR_SAVE_STEP:    save_step     = value[wso_pkg::STEP_W-1:0];
         // load the running total too
         wso_pkg::CSR_TOTAL_START:  total_held    = value[wso_pkg::DIST_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (idx)
         wso_pkg::CSR_WHEEL_LENGTH: stored = 64'(wheel_mm);
         wso_pkg::CSR_RPM_LIMIT:    stored = 64'(rpm_ceiling);
         wso_pkg::CSR_IDLE_TIMEOUT: stored = 64'(idle_limit_ms);
         wso_pkg::CSR_SAVE_STEP:    stored = 64'(save_step);
         default:                   stored = 64'(value[wso_pkg::DIST_W-1:0]);
      endcase
      if (!field_ok("register readback", stored, prdata)) csr_errors++;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic write_settings(input logic [63:0] wheel, input logic [63:0] ceiling,
                                 input logic [63:0] timeout, input logic [63:0] step_mm,
                                 input logic [63:0] start_mm);
      csr_write(wso_pkg::CSR_WHEEL_LENGTH, wheel);
      csr_write(wso_pkg::CSR_RPM_LIMIT, ceiling);
      csr_write(wso_pkg::CSR_IDLE_TIMEOUT, timeout);
      csr_write(wso_pkg::CSR_SAVE_STEP, step_mm);
      csr_write(wso_pkg::CSR_TOTAL_START, start_mm);
   endtask

   // Ride n evenly spaced turns; each turn is an arming low halfway, then a high.
   task automatic ride_turns(input logic [wso_pkg::TIME_W-1:0] first,
                             input int unsigned period, input int unsigned n);
      logic [wso_pkg::TIME_W-1:0] t;
      for (int k = 0; k < n; k++) begin
         t = first + 32'(k) * period;
         send_sample(t - period / 2, 1'b0);
         send_sample(t, 1'b1);
      end
   endtask

   // Mostly well-formed rides with random pace and jitter; some long pauses
   // that trip the idle check, and some fully random noise samples.
   task automatic ride_random(input int unsigned count);
      int unsigned target;
      int unsigned mode;
      int unsigned period;
      int unsigned jitter;
      int unsigned gap_ms;
      int unsigned turns;
      int unsigned lows;
      target = samples_sent + count;
      while (samples_sent < target) begin
         mode = $urandom_range(0, 99);
         if (mode < 72) begin
            mode = $urandom_range(0, 99);
            if (mode < 55)      period = $urandom_range(110, 2500);     // normal riding
            else if (mode < 70) period = $urandom_range(0, 120);        // near or over limit
            else if (mode < 85) period = $urandom_range(2500, 9000);    // slow, may go idle
            else if (mode < 93) period = $urandom_range(60000, 400000); // rpm zero or one, avg may clamp
            else                period = $urandom_range(900, 1100);
            turns = $urandom_range(1, 15);
            for (int k = 0; k < turns; k++) begin
               jitter = period / 8;
               gap_ms = period - jitter + $urandom_range(0, 2 * jitter);
               lows   = $urandom_range(1, 3);
               for (int j = 1; j <= lows; j++)
                  send_sample(ride_ms + gap_ms * 32'(j) / (lows + 1), 1'b0);
               ride_ms += gap_ms;
               send_sample(ride_ms, 1'b1);
               // a repeated high without arming must not count
               if ($urandom_range(0, 9) == 0) send_sample(ride_ms + $urandom_range(0, 20), 1'b1);
            end
         end else if (mode < 86) begin
            ride_ms += $urandom_range(0, 2 * 32'(idle_limit_ms) + 10);
            send_sample(ride_ms, 1'b0);
         end else begin
            ride_ms = $urandom;
            send_sample(ride_ms, $urandom_range(0, 1) != 0);
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Reset settings: unarmed high, a zero-length window, a window across the
   // timestamp wrap just under the rpm limit, then an idle timeout.
   task automatic test_directed_edges();
      send_sample(32'd0, 1'b1);
      ride_turns(32'd0, 0, 5);
      ride_turns(32'hFFFF_FF67, 101, 5);   // a low lands on the all-ones timestamp
      send_sample(32'hFFFF_FF67 + 32'd404 + 32'd4000, 1'b0);
      ride_ms = 32'hFFFF_FF67 + 32'd404 + 32'd4000;
   endtask

   task automatic test_default_ride();
      ride_random(200);
   endtask

   // Largest wheel and limits, save on every turn, total close to saturation.
   task automatic test_wide_settings();
      settle();
      write_settings(64'd4095, 64'd1023, 64'd65535, 64'd1, 64'hFF_FFFF_0000);
      ride_random(200);
   endtask

   // Smallest legal wheel, limit and timeout, largest save step: only a zero rpm gets under a limit of one.
   task automatic test_narrow_settings();
      settle();
      write_settings(64'd1, 64'd1, 64'd1, 64'd16777215, 64'd0);
      ride_random(150);
   endtask

   task automatic test_random_settings();
      logic [wso_pkg::DIST_W-1:0] start_mm;
      for (int r = 0; r < 3; r++) begin
         settle();
         start_mm = wso_pkg::DIST_W'({$urandom, $urandom});
         write_settings(64'($urandom_range(1, 4095)), 64'($urandom_range(1, 1023)),
                        64'($urandom_range(1, 65535)),
                        ($urandom_range(0, 3) == 0) ? 64'($urandom_range(1, 16777215))
                                                    : 64'($urandom_range(1, 40000)),
                        64'(start_mm));
         ride_random(120);
      end
   endtask

   // Zero wheel, zero limit, zero timeout and zero save step.
   task automatic test_degenerate_settings();
      settle();
      write_settings(64'd0, 64'd0, 64'd0, 64'd0, 64'd12345);
      ride_random(100);
   endtask

   // Back to reset values; hold the receiver off long enough that the block
   // fills and stalls its input while the sender keeps offering beats.
   task automatic test_backpressure();
      settle();
      write_settings(64'(wso_pkg::WHEEL_LENGTH_RESET), 64'(wso_pkg::RPM_LIMIT_RESET),
                     64'(wso_pkg::IDLE_TIMEOUT_RESET), 64'(wso_pkg::SAVE_STEP_RESET),
                     64'(wso_pkg::TOTAL_START_RESET));
      steady      = 1'b1;
      holds_asked = holds_asked + 1;
      ride_random(120);
      steady = 1'b0;
      ride_random(100);
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      steady       = 1'b0;
      holds_asked  = 0;
      samples_sent = 0;
      errors       = 0;
      csr_errors   = 0;
      ride_ms      = '0;

      // predictor matches the block's reset state
      wheel_mm        = wso_pkg::WHEEL_LENGTH_RESET;
      rpm_ceiling     = wso_pkg::RPM_LIMIT_RESET;
      idle_limit_ms   = wso_pkg::IDLE_TIMEOUT_RESET;
      save_step       = wso_pkg::SAVE_STEP_RESET;
      armed_now       = 1'b0;
      last_turn_ms    = '0;
      window_start_ms = '0;
      window_open     = 1'b0;
      turns_in_window = 0;
      rpm_held        = '0;
      speed_held      = '0;
      peak_held       = '0;
      mean_held       = '0;
      log_fill        = 0;
      trip_held       = '0;
      period_held     = '0;
      total_held      = wso_pkg::TOTAL_START_RESET;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_default_ride();
      test_wide_settings();
      test_narrow_settings();
      test_random_settings();
      test_degenerate_settings();
      test_backpressure();
      settle();

      if (errors == 0 && csr_errors == 0)
         $display("PASS wheel_speed_odometer_unit");
      else
         $display("FAIL wheel_speed_odometer_unit");
      $finish;
   end

endmodule

// File: filelist.f
src/wso_pkg.sv
src/wso_divider.sv
src/wso_csr.sv
src/wheel_speed_odometer_unit.sv
verif/tb_top.sv
